/* hw/rtl/ctca_pkg.sv */
// Shared types, request codes and fixed-point helpers for the colour
// transform compose/apply block. No dependencies.
`default_nettype none

package ctca_pkg;

  localparam int unsigned CHANNELS = 4;

  localparam logic [1:0] REQ_RESET   = 2'd0;
  localparam logic [1:0] REQ_COMPOSE = 2'd1;
  localparam logic [1:0] REQ_APPLY   = 2'd2;

  localparam logic signed [15:0] MULT_IDENTITY = 16'sd256;
  localparam logic signed [15:0] ADD_IDENTITY  = 16'sd0;
  localparam logic signed [24:0] SAT_HI        = 25'sd32767;
  localparam logic signed [24:0] SAT_LO        = -25'sd32768;
  localparam logic signed [24:0] PIX_MAX       = 25'sd255;

  typedef struct packed {
    logic identity;
    logic compose;
  } ctca_ctrl_t;

  // Divide by 256, rounding toward zero.
  function automatic logic signed [23:0] div256_trunc(input logic signed [31:0] p);
    logic signed [31:0] adj;
    adj = p + (p[31] ? 32'sd255 : 32'sd0);
    return adj[31:8];
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [24:0] v);
    logic signed [15:0] r;
    if (v > SAT_HI) begin
      r = 16'sh7fff;
    end else if (v < SAT_LO) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/ctca_in_if.sv */
// Request channel of the colour transform block: valid/ready plus the
// request fields. No dependencies.
`default_nettype none

interface ctca_in_if;
  logic              valid;
  logic              ready;
  logic [1:0]        req_type;
  logic signed [15:0] mult_r;
  logic signed [15:0] mult_g;
  logic signed [15:0] mult_b;
  logic signed [15:0] mult_a;
  logic signed [15:0] add_r;
  logic signed [15:0] add_g;
  logic signed [15:0] add_b;
  logic signed [15:0] add_a;
  logic [31:0]       pixel;

  modport source (
    output valid, req_type, mult_r, mult_g, mult_b, mult_a,
    output add_r, add_g, add_b, add_a, pixel,
    input  ready
  );
  modport sink (
    input  valid, req_type, mult_r, mult_g, mult_b, mult_a,
    input  add_r, add_g, add_b, add_a, pixel,
    output ready
  );
endinterface

`default_nettype wire

/* hw/rtl/ctca_out_if.sv */
// Result channel of the colour transform block: valid/ready plus the
// four clamped channel values. No dependencies.
`default_nettype none

interface ctca_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_r;
  logic [7:0] out_g;
  logic [7:0] out_b;
  logic [7:0] out_a;

  modport source (
    output valid, out_r, out_g, out_b, out_a,
    input  ready
  );
  modport sink (
    input  valid, out_r, out_g, out_b, out_a,
    output ready
  );
endinterface

`default_nettype wire

/* hw/rtl/ctca_lane.sv */
// One channel lane: holds the accumulated multiplier/addend, updates them on
// identity or compose, and maps one 8-bit channel value. Uses ctca_pkg.
`default_nettype none

module ctca_lane import ctca_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire ctca_ctrl_t        ctrl,
  input  wire logic signed [15:0] in_mult,
  input  wire logic signed [15:0] in_add,
  input  wire logic [7:0]        pix,
  output logic [7:0]             value
);

  logic signed [15:0] mult;
  logic signed [15:0] add;
  logic signed [15:0] mult_next;
  logic signed [15:0] add_next;

  logic signed [31:0] cm_prod;
  logic signed [31:0] ca_prod;
  logic signed [24:0] ca_sum;
  logic signed [8:0]  pv;
  logic signed [24:0] ap_prod;
  logic signed [24:0] ap_sum;

  always_comb begin
    cm_prod = mult * in_mult;
    ca_prod = mult * in_add;
    ca_sum  = 25'(div256_trunc(ca_prod)) + 25'(add);

    mult_next = mult;
    add_next  = add;
    if (ctrl.identity) begin
      mult_next = MULT_IDENTITY;
      add_next  = ADD_IDENTITY;
    end else if (ctrl.compose) begin
      mult_next = sat16(25'(div256_trunc(cm_prod)));
      add_next  = sat16(ca_sum);
    end
  end

  always_comb begin
    pv      = signed'({1'b0, pix});
    ap_prod = pv * mult;
    ap_sum  = 25'(div256_trunc(32'(ap_prod))) + 25'(add);
    if (ap_sum[24]) begin
      value = 8'd0;
    end else if (ap_sum > PIX_MAX) begin
      value = 8'd255;
    end else begin
      value = ap_sum[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mult <= MULT_IDENTITY;
      add  <= ADD_IDENTITY;
    end else begin
      mult <= mult_next;
      add  <= add_next;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/ctca_merge.sv */
// Output stage: gathers the four lane values of an apply item into the
// result register and runs the result handshake. Uses ctca_pkg, ctca_out_if.
`default_nettype none

module ctca_merge import ctca_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       load,
  input  wire logic [7:0] lane_val [CHANNELS],
  output logic            space,
  ctca_out_if.source      rsp
);

  logic       valid;
  logic [7:0] r;
  logic [7:0] g;
  logic [7:0] b;
  logic [7:0] a;

  assign space     = !valid || rsp.ready;
  assign rsp.valid = valid;
  assign rsp.out_r = r;
  assign rsp.out_g = g;
  assign rsp.out_b = b;
  assign rsp.out_a = a;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (rsp.ready) begin
      valid <= 1'b0;
    end
  end

  // hold the payload until the next apply item is loaded
  always_ff @(posedge clk) begin
    if (load) begin
      r <= lane_val[0];
      g <= lane_val[1];
      b <= lane_val[2];
      a <= lane_val[3];
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/colour_transform_compose_apply_core.sv */
// Colour transform compose/apply block, top level.
// Uses ctca_pkg, ctca_in_if, ctca_out_if, ctca_lane and ctca_merge.
//
// Channels: req (sink) carries one request item per handshake: req_type
// selects reset-to-identity, compose with the inner transform in
// mult_*/add_*, or apply to the RGBA pixel. rsp (source) carries one
// result item, the four clamped channel values, for every apply item only.
// Reset, compose and unused request codes give no result.
//
// Four channel lanes work in parallel; each holds its own multiplier and
// addend and does a compose or an apply. The output register collects the
// lane values.
// Throughput: one item per clock while req.ready is high. An apply result is valid in the
// cycle after the item is accepted. A compose or reset takes effect for the
// item accepted in the very next cycle.
// Stall: req.ready stays high while the result register is empty or being
// taken; while rsp is stalled with a result pending, req.ready drops.
// Reset (rst, synchronous): the transform returns to identity (multiplier
// 256, addend 0) in every channel and the result register empties.
`default_nettype none

module colour_transform_compose_apply_core import ctca_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  ctca_in_if.sink    req,
  ctca_out_if.source rsp
);

  logic               space;
  logic               fire;
  ctca_ctrl_t         ctrl;
  logic               apply;
  logic signed [15:0] lane_mult [CHANNELS];
  logic signed [15:0] lane_add  [CHANNELS];
  logic [7:0]         lane_pix  [CHANNELS];
  logic [7:0]         lane_val  [CHANNELS];

  assign req.ready = space;
  assign fire      = req.valid && space;

  always_comb begin
    ctrl.identity = fire && (req.req_type == REQ_RESET);
    ctrl.compose  = fire && (req.req_type == REQ_COMPOSE);
    apply         = fire && (req.req_type == REQ_APPLY);

    lane_mult[0] = req.mult_r;
    lane_mult[1] = req.mult_g;
    lane_mult[2] = req.mult_b;
    lane_mult[3] = req.mult_a;
    lane_add[0]  = req.add_r;
    lane_add[1]  = req.add_g;
    lane_add[2]  = req.add_b;
    lane_add[3]  = req.add_a;
    lane_pix[0]  = req.pixel[7:0];
    lane_pix[1]  = req.pixel[15:8];
    lane_pix[2]  = req.pixel[23:16];
    lane_pix[3]  = req.pixel[31:24];
  end

  for (genvar k = 0; k < CHANNELS; k++) begin : g_lane
    ctca_lane u_lane (
      .clk     (clk),
      .rst     (rst),
      .ctrl    (ctrl),
      .in_mult (lane_mult[k]),
      .in_add  (lane_add[k]),
      .pix     (lane_pix[k]),
      .value   (lane_val[k])
    );
  end

  ctca_merge u_merge (
    .clk      (clk),
    .rst      (rst),
    .load     (apply),
    .lane_val (lane_val),
    .space    (space),
    .rsp      (rsp)
  );

endmodule

`default_nettype wire

/* hw/rtl/ctca_checker.sv */
// Port-level checks for the colour transform block, bound to the top level.
// Uses ctca_pkg.
`default_nettype none

module ctca_checker import ctca_pkg::*; (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       req_valid,
  input wire logic       req_ready,
  input wire logic [1:0] req_type,
  input wire logic       rsp_valid,
  input wire logic       rsp_ready,
  input wire logic [7:0] out_r
);

  logic req_fire;
  assign req_fire = req_valid && req_ready;

  a_rst_empty: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("result pending right after reset");

  a_apply_result: assert property (@(posedge clk) disable iff (rst)
    (req_fire && req_type == REQ_APPLY) |=> rsp_valid)
    else $error("apply item gave no result");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    (req_fire && req_type != REQ_APPLY && (!rsp_valid || rsp_ready)) |=> !rsp_valid)
    else $error("result without an apply item");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(out_r)))
    else $error("stalled result dropped or changed");

endmodule

bind colour_transform_compose_apply_core ctca_checker u_ctca_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req.valid),
  .req_ready (req.ready),
  .req_type  (req.req_type),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .out_r     (rsp.out_r)
);

`default_nettype wire

/* test/colour_transform_compose_apply_core_tb.sv */
// Self-checking testbench for colour_transform_compose_apply_core: a table of
// directed requests, then random ones, checked against an internal predictor.
// Depends on ctca_pkg, ctca_in_if, ctca_out_if and the block itself.

module colour_transform_compose_apply_core_tb import ctca_pkg::*;;

  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 1700;

  typedef struct packed {
    logic [1:0]       kind;
    logic [3:0][15:0] mult;   // index 0 is red, 3 is alpha
    logic [3:0][15:0] add;
    logic [31:0]      pixel;
  } xform_req_t;

  typedef struct packed {
    xform_req_t  req;
    logic        known;
    logic [31:0] want;        // {a, b, g, r}, used when known
  } directed_row_t;

  logic clk;
  logic rst;

  ctca_in_if  req_if ();
  ctca_out_if rsp_if ();

  colour_transform_compose_apply_core dut (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .rsp (rsp_if)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predicted transform state, one entry per channel.
  logic signed [15:0] acc_mult [4];
  logic signed [15:0] acc_add  [4];

  logic [3:0][7:0] expected_pixels [$];
  directed_row_t   directed_rows [$];

  int errors;
  int n_apply, n_compose, n_reset, n_ignored, n_checked;
  int burst_left;

  task automatic report_mismatch(input string what);
    if (errors < 50) $display("MISMATCH at %0t: %s", $realtime, what);
    errors++;
  endtask

  function automatic logic signed [15:0] sat_s16(input longint v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return 16'(v);
  endfunction

  function automatic void identity_transform();
    for (int k = 0; k < 4; k++) begin
      acc_mult[k] = MULT_IDENTITY;
      acc_add[k]  = ADD_IDENTITY;
    end
  endfunction

  // Update the predicted transform; return 1 with the pixel for an apply.
  function automatic bit transform_request(input xform_req_t r,
                                           output logic [3:0][7:0] px);
    longint om, im, ia, v, t;
    px = '0;
    case (r.kind)
      REQ_RESET: begin
        identity_transform();
        return 1'b0;
      end
      REQ_COMPOSE: begin
        for (int k = 0; k < 4; k++) begin
          om = acc_mult[k];
          im = $signed(r.mult[k]);
          ia = $signed(r.add[k]);
          acc_mult[k] = sat_s16((om * im) / 256);
          acc_add[k]  = sat_s16((om * ia) / 256 + longint'(acc_add[k]));
        end
        return 1'b0;
      end
      REQ_APPLY: begin
        for (int k = 0; k < 4; k++) begin
          v = r.pixel[8*k +: 8];
          t = (v * longint'(acc_mult[k])) / 256 + longint'(acc_add[k]);
          if (t < 0) t = 0;
          if (t > 255) t = 255;
          px[k] = 8'(t);
        end
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic directed_row_t stim_row(input logic [1:0] kind,
                                             input logic [63:0] mult,
                                             input logic [63:0] add,
                                             input logic [31:0] pixel,
                                             input logic known,
                                             input logic [31:0] want);
    directed_row_t d;
    d.req.kind  = kind;
    d.req.mult  = mult;
    d.req.add   = add;
    d.req.pixel = pixel;
    d.known     = known;
    d.want      = want;
    return d;
  endfunction

  function automatic xform_req_t random_request();
    xform_req_t r;
    int sel;
    sel = $urandom_range(0, 99);
    r.mult  = {$urandom, $urandom};
    r.add   = {$urandom, $urandom};
    r.pixel = $urandom;
    if (sel < 10) r.kind = REQ_RESET;
    else if (sel < 35) r.kind = REQ_COMPOSE;
    else if (sel < 93) r.kind = REQ_APPLY;
    else r.kind = REQ_UNUSED;
    // Keep most composes to multipliers of -320..320 and addends of -300..300.
    if (r.kind == REQ_COMPOSE && $urandom_range(0, 4) != 0) begin
      for (int k = 0; k < 4; k++) begin
        r.mult[k] = 16'(int'($urandom_range(0, 640)) - 320);
        r.add[k]  = 16'(int'($urandom_range(0, 600)) - 300);
      end
    end
    return r;
  endfunction

  // Called at a falling edge; returns at a falling edge.
  task automatic send_request(input xform_req_t r, input logic known,
                              input logic [31:0] want);
    logic [3:0][7:0] px;
    int gap;
    req_if.req_type = r.kind;
    req_if.mult_r   = r.mult[0];
    req_if.mult_g   = r.mult[1];
    req_if.mult_b   = r.mult[2];
    req_if.mult_a   = r.mult[3];
    req_if.add_r    = r.add[0];
    req_if.add_g    = r.add[1];
    req_if.add_b    = r.add[2];
    req_if.add_a    = r.add[3];
    req_if.pixel    = r.pixel;
    req_if.valid    = 1'b1;
    do @(posedge clk); while (!req_if.ready);
    if (transform_request(r, px)) expected_pixels.push_back(known ? want : px);
    case (r.kind)
      REQ_RESET:   n_reset++;
      REQ_COMPOSE: n_compose++;
      REQ_APPLY:   n_apply++;
      default:     n_ignored++;
    endcase
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
    end else begin
      gap = 0;
    end
    @(negedge clk);
    if (gap > 0) begin
      req_if.valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // Result side: stall in modes (always ready, random, bursts) that change when mode_cycles runs out.
  int stall_mode, stall_left, mode_cycles;
  initial rsp_if.ready = 1'b0;
  always @(negedge clk) begin
    if (mode_cycles == 0) begin
      stall_mode  <= $urandom_range(0, 2);
      mode_cycles <= 200;
      rsp_if.ready <= 1'b1;
    end else begin
      mode_cycles <= mode_cycles - 1;
      case (stall_mode)
        0: rsp_if.ready <= 1'b1;
        1: rsp_if.ready <= ($urandom_range(0, 3) != 0);
        default: begin
          if (stall_left > 0) begin
            rsp_if.ready <= 1'b0;
            stall_left <= stall_left - 1;
          end else begin
            rsp_if.ready <= 1'b1;
            if ($urandom_range(0, 9) == 0) stall_left <= $urandom_range(1, 12);
          end
        end
      endcase
    end
  end

  always @(posedge clk) begin : check_results
    logic [3:0][7:0] want;
    if (!rst && rsp_if.valid && rsp_if.ready) begin
      if (expected_pixels.size() == 0) begin
        report_mismatch("result item with nothing expected");
      end else begin
        want = expected_pixels.pop_front();
        n_checked++;
        if (rsp_if.out_r !== want[0])
          report_mismatch($sformatf("out_r %0d, want %0d", rsp_if.out_r, want[0]));
        if (rsp_if.out_g !== want[1])
          report_mismatch($sformatf("out_g %0d, want %0d", rsp_if.out_g, want[1]));
        if (rsp_if.out_b !== want[2])
          report_mismatch($sformatf("out_b %0d, want %0d", rsp_if.out_b, want[2]));
        if (rsp_if.out_a !== want[3])
          report_mismatch($sformatf("out_a %0d, want %0d", rsp_if.out_a, want[3]));
      end
    end
  end

  initial begin
    #5_000_000;
    $display("colour_transform_compose_apply_core_tb failed");
    $finish;
  end

  initial begin
    int waited;
    errors = 0;
    n_apply = 0; n_compose = 0; n_reset = 0; n_ignored = 0; n_checked = 0;
    burst_left = 0;
    stall_mode = 0; stall_left = 0; mode_cycles = 0;
    identity_transform();
    rst = 1'b1;
    req_if.valid    = 1'b0;
    req_if.req_type = REQ_RESET;
    req_if.mult_r = '0; req_if.mult_g = '0; req_if.mult_b = '0; req_if.mult_a = '0;
    req_if.add_r  = '0; req_if.add_g  = '0; req_if.add_b  = '0; req_if.add_a  = '0;
    req_if.pixel  = '0;

    //                         kind         mult                    add
    //                         pixel          known  want {a,b,g,r}
    directed_rows.push_back(stim_row(REQ_APPLY,   64'h0, 64'h0,
                                     32'h80ff_0001, 1'b1, 32'h80ff_0001));
    directed_rows.push_back(stim_row(REQ_APPLY,   '1, '1,
                                     32'hffff_ffff, 1'b1, 32'hffff_ffff));
    directed_rows.push_back(stim_row(REQ_APPLY,   '1, '1,
                                     32'h0000_0000, 1'b1, 32'h0000_0000));
    directed_rows.push_back(stim_row(REQ_COMPOSE, 64'h7fff_7fff_7fff_7fff,
                                     64'h7fff_7fff_7fff_7fff,
                                     32'hffff_ffff, 1'b0, 32'h0));
    directed_rows.push_back(stim_row(REQ_APPLY,   64'h0, 64'h0,
                                     32'h0101_0101, 1'b1, 32'hffff_ffff));
    // Product saturates high; the addend stays at the positive rail.
    directed_rows.push_back(stim_row(REQ_COMPOSE, 64'h7fff_7fff_7fff_7fff, 64'h0,
                                     32'h0, 1'b0, 32'h0));
    directed_rows.push_back(stim_row(REQ_APPLY,   64'h0, 64'h0,
                                     32'h8040_2010, 1'b0, 32'h0));
    directed_rows.push_back(stim_row(REQ_RESET,   64'h8000_8000_8000_8000,
                                     64'h8000_8000_8000_8000,
                                     32'h5555_aaaa, 1'b0, 32'h0));
    directed_rows.push_back(stim_row(REQ_APPLY,   64'h0, 64'h0,
                                     32'h1234_5678, 1'b1, 32'h1234_5678));
    directed_rows.push_back(stim_row(REQ_COMPOSE, 64'h8000_8000_8000_8000,
                                     64'h8000_8000_8000_8000,
                                     32'h0, 1'b0, 32'h0));
    directed_rows.push_back(stim_row(REQ_APPLY,   64'h0, 64'h0,
                                     32'hffff_ffff, 1'b1, 32'h0000_0000));
    // Most negative times most negative: saturates to the positive rail.
    directed_rows.push_back(stim_row(REQ_COMPOSE, 64'h8000_8000_8000_8000, 64'h0,
                                     32'h0, 1'b0, 32'h0));
    directed_rows.push_back(stim_row(REQ_APPLY,   64'h0, 64'h0,
                                     32'h7f80_01fe, 1'b0, 32'h0));
    // Unused request code must leave the transform alone.
    directed_rows.push_back(stim_row(REQ_UNUSED,  '1, '1,
                                     32'hffff_ffff, 1'b0, 32'h0));
    directed_rows.push_back(stim_row(REQ_APPLY,   64'h0, 64'h0,
                                     32'h0102_0304, 1'b0, 32'h0));
    directed_rows.push_back(stim_row(REQ_RESET,   64'h0, 64'h0,
                                     32'h0, 1'b0, 32'h0));
    // Gain of -1/256: the product truncates to zero, not down to -1.
    directed_rows.push_back(stim_row(REQ_COMPOSE, 64'hffff_ffff_ffff_ffff,
                                     64'h0001_0001_0001_0001,
                                     32'h0, 1'b0, 32'h0));
    directed_rows.push_back(stim_row(REQ_APPLY,   64'h0, 64'h0,
                                     32'hffff_ffff, 1'b1, 32'h0101_0101));
    directed_rows.push_back(stim_row(REQ_RESET,   64'h0, 64'h0,
                                     32'h0, 1'b0, 32'h0));
    directed_rows.push_back(stim_row(REQ_COMPOSE, 64'hff00_0000_0200_0080,
                                     64'h00ff_012c_fff6_000a,
                                     32'h0, 1'b0, 32'h0));
    directed_rows.push_back(stim_row(REQ_APPLY,   64'h0, 64'h0,
                                     32'h4020_9003, 1'b1, 32'hbfff_ff0b));
    directed_rows.push_back(stim_row(REQ_COMPOSE, 64'h0180_0100_0040_fe80,
                                     64'hff38_0064_0000_8000,
                                     32'h0, 1'b0, 32'h0));
    directed_rows.push_back(stim_row(REQ_APPLY,   64'h0, 64'h0,
                                     32'hc0c0_c0c0, 1'b0, 32'h0));
    directed_rows.push_back(stim_row(REQ_RESET,   64'h0, 64'h0,
                                     32'h0, 1'b0, 32'h0));
    directed_rows.push_back(stim_row(REQ_APPLY,   64'h0, 64'h0,
                                     32'h00ff_ff00, 1'b1, 32'h00ff_ff00));

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (directed_rows[i])
      send_request(directed_rows[i].req, directed_rows[i].known, directed_rows[i].want);
    for (int i = 0; i < RANDOM_ITEMS; i++)
      send_request(random_request(), 1'b0, 32'h0);
    req_if.valid = 1'b0;

    waited = 0;
    while (expected_pixels.size() != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    repeat (10) @(posedge clk);
    while (expected_pixels.size() != 0) begin
      void'(expected_pixels.pop_front());
      report_mismatch("expected result item never arrived");
    end

    $display("Sent %0d applies, %0d composes, %0d resets, %0d unused-code items;",
             n_apply, n_compose, n_reset, n_ignored);
    $display("checked %0d result items, %0d mismatches.", n_checked, errors);
    if (errors == 0) begin
      $display("colour_transform_compose_apply_core_tb passed");
    end else begin
      $display("colour_transform_compose_apply_core_tb failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/ctca_pkg.sv
hw/rtl/ctca_in_if.sv
hw/rtl/ctca_out_if.sv
hw/rtl/ctca_lane.sv
hw/rtl/ctca_merge.sv
hw/rtl/colour_transform_compose_apply_core.sv
hw/rtl/ctca_checker.sv
test/colour_transform_compose_apply_core_tb.sv
